[design/ipr_pkg.sv]
// ----------------------------------------------------------------------------
// Image plane rotation scatter package
// Shared widths, register indexes, rotation codes and the job record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ipr_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int CNT_W     = $clog2(MAX_DIM);
	localparam int DIM_W     = CNT_W + 1;
	localparam int PIX_W     = 8;
	localparam int IDX_W     = 24;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = CNT_W + DIM_W;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(640);
	localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

	typedef enum logic [MODE_W-1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] mcand;
		logic [DIM_W-1:0] mplier;
		logic [CNT_W-1:0] addend;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} ipr_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ipr_qstat_t;

	// A dimension of zero counts as one, and anything above the limit is clamped.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[design/ipr_in_if.sv]
// ----------------------------------------------------------------------------
// Source pixel channel
// Valid/ready channel that carries one source byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipr_in_if;
	import ipr_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

[design/ipr_out_if.sv]
// ----------------------------------------------------------------------------
// Scattered pixel channel
// Valid/ready channel that carries a byte with its destination index.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipr_out_if;
	import ipr_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] dest_index;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;

	modport source (output valid, output dest_index, output pixel_out, output frame_last,
		input ready);
	modport sink (input valid, input dest_index, input pixel_out, input frame_last,
		output ready);
endinterface

`default_nettype wire

[design/ipr_front.sv]
// ----------------------------------------------------------------------------
// Rotation front end
// Holds the configuration and the row and column counters, and turns each
// accepted byte into multiply-add operands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ipr_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ipr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ipr_pkg::DIM_W-1:0]      cfg_data,
	ipr_in_if.sink                              src,
	input  wire logic                           q_full,
	output logic                                push,
	output ipr_pkg::ipr_job_t                   job
);
	import ipr_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	rot_mode_t        mode_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [DIM_W-1:0] col_nxt;
	logic [DIM_W-1:0] row_nxt;
	logic [DIM_W-1:0] h_m1_r;
	logic [DIM_W-1:0] w_m1_c;
	logic             col_end;
	logic             row_end;
	logic             cfg_hit;

	assign w_eff   = eff_dim(width_q);
	assign h_eff   = eff_dim(height_q);
	assign col_nxt = {1'b0, col_q} + DIM_W'(1);
	assign row_nxt = {1'b0, row_q} + DIM_W'(1);
	assign col_end = col_nxt >= w_eff;
	assign row_end = row_nxt >= h_eff;
	assign h_m1_r  = h_eff - row_nxt;
	assign w_m1_c  = w_eff - col_nxt;

	assign src.ready = !q_full;
	assign push      = src.valid && !q_full;
	assign cfg_hit   = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
		cfg_index == REG_MODE);

	always_comb begin
		job.pixel = src.pixel_in;
		job.last  = col_end && row_end;
		unique case (mode_q)
			ROT_90: begin
				job.mcand  = col_q;
				job.mplier = h_eff;
				job.addend = h_m1_r[CNT_W-1:0];
			end
			ROT_180: begin
				job.mcand  = h_m1_r[CNT_W-1:0];
				job.mplier = w_eff;
				job.addend = w_m1_c[CNT_W-1:0];
			end
			ROT_270: begin
				job.mcand  = w_m1_c[CNT_W-1:0];
				job.mplier = h_eff;
				job.addend = row_q;
			end
			default: begin
				job.mcand  = row_q;
				job.mplier = w_eff;
				job.addend = col_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			mode_q   <= ROT_0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_MODE:   mode_q   <= rot_mode_t'(cfg_data[MODE_W-1:0]);
				default: ;
			endcase
			if (cfg_hit) begin
				row_q <= '0;
				col_q <= '0;
			end
		end else if (push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_nxt[CNT_W-1:0];
			end else begin
				col_q <= col_nxt[CNT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

[design/ipr_fifo.sv]
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ipr_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire ipr_pkg::ipr_job_t  push_data,
	input  wire logic               pop,
	output ipr_pkg::ipr_job_t       pop_data,
	output ipr_pkg::ipr_qstat_t     stat
);
	import ipr_pkg::*;

	ipr_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign stat.full  = cnt_q == (QPTR_W + 1)'(QDEPTH);
	assign stat.empty = cnt_q == '0;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/ipr_back.sv]
// ----------------------------------------------------------------------------
// Rotation back end
// Takes jobs from the queue, forms the destination index with one
// multiply-add and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ipr_pkg::ipr_job_t  head,
	input  wire logic               q_empty,
	output logic                    pop,
	ipr_out_if.source               dst
);
	import ipr_pkg::*;

	logic              valid_q;
	logic [IDX_W-1:0]  dest_q;
	logic [PIX_W-1:0]  pixel_q;
	logic              last_q;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] sum;

	assign prod = PROD_W'(head.mcand) * PROD_W'(head.mplier);
	assign sum  = prod + PROD_W'(head.addend);
	assign pop  = !q_empty && (!valid_q || dst.ready);

	assign dst.valid      = valid_q;
	assign dst.dest_index = dest_q;
	assign dst.pixel_out  = pixel_q;
	assign dst.frame_last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (dst.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dest_q  <= sum[IDX_W-1:0];
			pixel_q <= head.pixel;
			last_q  <= head.last;
		end
	end

endmodule

`default_nettype wire

[design/image_plane_rotation_scatter.sv]
// ----------------------------------------------------------------------------
// Image plane rotation scatter
// Gives each raster-order source byte its index in a plane rotated by 0, 90,
// 180 or 270 degrees, and marks the last byte of each frame.
// ----------------------------------------------------------------------------
// Path: a transferred byte is written into the queue and, once the output is
// free, its result is taken into the output register and presented.
// Throughput: one byte per cycle while neither channel stalls, set by the single
// multiply-add in the back end; a four-entry queue lets input and output stall on their own.
// Reset: configuration returns to 640 by 480 with no rotation, counters and
// queue are cleared, and no result is pending.
`default_nettype none

module image_plane_rotation_scatter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ipr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ipr_pkg::DIM_W-1:0]      cfg_data,
	ipr_in_if.sink                              src,
	ipr_out_if.source                           dst
);
	import ipr_pkg::*;

	ipr_job_t   job;
	ipr_job_t   head;
	ipr_qstat_t q_stat;
	logic       q_push;
	logic       q_pop;

	ipr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src       (src),
		.q_full    (q_stat.full),
		.push      (q_push),
		.job       (job)
	);

	ipr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (job),
		.pop       (q_pop),
		.pop_data  (head),
		.stat      (q_stat)
	);

	ipr_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_stat.empty),
		.pop     (q_pop),
		.dst     (dst)
	);

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("back end took a job from an empty queue");

	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.empty && !q_push) |=> q_stat.empty)
		else $error("queue filled without a push");

	a_out_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(dst.valid)) |-> $past(q_pop))
		else $error("result appeared without a job");

endmodule

`default_nettype wire

[bench/image_plane_rotation_scatter_tb.sv]
// ----------------------------------------------------------------------------
// Image plane rotation scatter testbench
// Streams source bytes through the block under valid/ready back-pressure and
// checks every destination index, byte and end-of-frame mark against an
// in-bench model of the raster counters and the four rotations. A short
// directed script covers reset values, clamped dimensions, every rotation
// and unknown register writes; randomized frame settings follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module image_plane_rotation_scatter_tb;
	import ipr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned PIXELS_PER_SEGMENT = 500;

	typedef struct packed {
		logic [IDX_W-1:0] dest_index;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} placement_t;

	typedef enum logic [1:0] {
		STEP_WRITE,
		STEP_PIXEL,
		STEP_CHECKED
	} step_kind_t;

	typedef struct packed {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] index;
		logic [DIM_W-1:0]     data;
		logic [PIX_W-1:0]     pixel;
		logic [IDX_W-1:0]     dest_index;
		logic                 last;
	} step_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	ipr_in_if  pixel_ch ();
	ipr_out_if placement_ch ();

	image_plane_rotation_scatter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src       (pixel_ch),
		.dst       (placement_ch)
	);

	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	rot_mode_t        mode_reg;
	logic [CNT_W-1:0] row_pos;
	logic [CNT_W-1:0] col_pos;

	placement_t  pending_placements[$];
	step_t       script[$];
	int unsigned pixels_sent;
	int unsigned errors;
	int unsigned src_idle_pct;
	int unsigned dst_idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > DIM_W'(MAX_DIM)) begin
			return MAX_DIM;
		end
		return 32'(v);
	endfunction

	function automatic placement_t next_placement(input logic [PIX_W-1:0] px);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned idx;
		bit          row_end;
		bit          col_end;
		placement_t  p;
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		r = 32'(row_pos);
		c = 32'(col_pos);
		if (r >= h) begin
			r = h - 1;
		end
		if (c >= w) begin
			c = w - 1;
		end
		case (mode_reg)
			ROT_90: begin
				idx = c * h + (h - 1 - r);
			end
			ROT_180: begin
				idx = (h - 1 - r) * w + (w - 1 - c);
			end
			ROT_270: begin
				idx = (w - 1 - c) * h + r;
			end
			default: begin
				idx = r * w + c;
			end
		endcase
		col_end = (c + 1 >= w);
		row_end = (r + 1 >= h);
		p.dest_index = IDX_W'(idx);
		p.pixel = px;
		p.last = col_end && row_end;
		if (col_end) begin
			col_pos = '0;
			row_pos = row_end ? '0 : CNT_W'(r + 1);
		end else begin
			col_pos = CNT_W'(c + 1);
			row_pos = CNT_W'(r);
		end
		return p;
	endfunction

	function automatic void apply_write(input logic [CFG_IDX_W-1:0] index,
		input logic [DIM_W-1:0] data);
		case (index)
			REG_WIDTH: begin
				width_reg = data;
			end
			REG_HEIGHT: begin
				height_reg = data;
			end
			REG_MODE: begin
				mode_reg = rot_mode_t'(data[MODE_W-1:0]);
			end
			default: begin
				return;
			end
		endcase
		row_pos = '0;
		col_pos = '0;
	endfunction

	function automatic step_t wr(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] data);
		step_t s;
		s = '0;
		s.kind = STEP_WRITE;
		s.index = index;
		s.data = data;
		return s;
	endfunction

	function automatic step_t px(input logic [PIX_W-1:0] pixel);
		step_t s;
		s = '0;
		s.kind = STEP_PIXEL;
		s.pixel = pixel;
		return s;
	endfunction

	function automatic step_t chk(input logic [PIX_W-1:0] pixel, input logic [IDX_W-1:0] dest_index,
		input logic last);
		step_t s;
		s = '0;
		s.kind = STEP_CHECKED;
		s.pixel = pixel;
		s.dest_index = dest_index;
		s.last = last;
		return s;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4) begin
			return '0;
		end
		if (roll < 8) begin
			return DIM_W'($urandom_range(MAX_DIM, 8191));
		end
		if (roll < 70) begin
			return DIM_W'($urandom_range(1, 12));
		end
		return DIM_W'($urandom_range(13, 64));
	endfunction

	task automatic drain_results();
		pixel_ch.valid <= 1'b0;
		while (pending_placements.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] data);
		drain_results();
		repeat (2) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		apply_write(index, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pixel, input bit typed,
		input logic [IDX_W-1:0] dest_index, input logic last);
		placement_t p;
		while ($urandom_range(99) < src_idle_pct) begin
			pixel_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.pixel_in <= pixel;
		do begin
			@(posedge clk);
		end while (!pixel_ch.ready);
		p = next_placement(pixel);
		if (typed) begin
			p.dest_index = dest_index;
			p.last = last;
		end
		pending_placements.push_back(p);
		pixels_sent++;
	endtask

	task automatic run_frame_setting();
		int unsigned area;
		int unsigned count;
		int unsigned pause_at;
		if ($urandom_range(3) != 0) begin
			write_reg(REG_WIDTH, pick_dim());
		end
		if ($urandom_range(3) != 0) begin
			write_reg(REG_HEIGHT, pick_dim());
		end
		if ($urandom_range(3) != 0) begin
			write_reg(REG_MODE, DIM_W'($urandom_range(8191)));
		end
		if ($urandom_range(7) == 0) begin
			write_reg(REG_UNUSED, DIM_W'($urandom_range(8191)));
		end
		area = clamp_dim(width_reg) * clamp_dim(height_reg);
		if (area <= 100) begin
			count = area * $urandom_range(1, 3);
			if ($urandom_range(3) == 0) begin
				count += $urandom_range(area - 1);
			end
		end else begin
			count = $urandom_range(20, 120);
		end
		pause_at = ($urandom_range(3) == 0) ? $urandom_range(count - 1) : count;
		for (int unsigned i = 0; i < count; i++) begin
			if (i == pause_at && i != 0) begin
				drain_results();
			end
			send_pixel(PIX_W'($urandom_range(255)), 1'b0, '0, 1'b0);
		end
	endtask

	task automatic report(input string field, input int unsigned want, input int unsigned got);
		errors++;
		$display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk) begin
		placement_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	always @(posedge clk) begin : check_placements
		placement_t want;
		if (arst_n && placement_ch.valid && placement_ch.ready) begin
			if (pending_placements.size() == 0) begin
				report("transfer with nothing pending, dest_index", 0,
					32'(placement_ch.dest_index));
			end else begin
				want = pending_placements.pop_front();
				if (placement_ch.dest_index !== want.dest_index) begin
					report("dest_index", 32'(want.dest_index), 32'(placement_ch.dest_index));
				end
				if (placement_ch.pixel_out !== want.pixel) begin
					report("pixel_out", 32'(want.pixel), 32'(placement_ch.pixel_out));
				end
				if (placement_ch.frame_last !== want.last) begin
					report("frame_last", 32'(want.last), 32'(placement_ch.frame_last));
				end
			end
		end
	end

	initial begin
		int unsigned segment_end;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.pixel_in <= '0;
		width_reg = WIDTH_RST;
		height_reg = HEIGHT_RST;
		mode_reg = ROT_0;
		row_pos = '0;
		col_pos = '0;
		pixels_sent = 0;
		errors = 0;
		src_idle_pct = 33;
		dst_idle_pct = 47;

		script.push_back(chk(8'h00, 24'd0, 1'b0));
		script.push_back(chk(8'hFF, 24'd1, 1'b0));
		script.push_back(wr(REG_WIDTH, 13'd1));
		script.push_back(wr(REG_HEIGHT, 13'd1));
		script.push_back(chk(8'h5A, 24'd0, 1'b1));
		script.push_back(chk(8'hA5, 24'd0, 1'b1));
		script.push_back(wr(REG_WIDTH, 13'd0));
		script.push_back(wr(REG_HEIGHT, 13'd0));
		script.push_back(chk(8'h3C, 24'd0, 1'b1));
		script.push_back(wr(REG_WIDTH, 13'd8191));
		script.push_back(wr(REG_HEIGHT, 13'd8191));
		script.push_back(wr(REG_MODE, DIM_W'(ROT_180)));
		script.push_back(chk(8'hC3, 24'hFFFFFF, 1'b0));
		script.push_back(wr(REG_MODE, DIM_W'(ROT_270)));
		script.push_back(chk(8'h81, 24'd16773120, 1'b0));
		script.push_back(px(8'h7E));
		script.push_back(wr(REG_MODE, DIM_W'(ROT_90)));
		script.push_back(chk(8'h01, 24'd4095, 1'b0));
		script.push_back(wr(REG_WIDTH, 13'd4096));
		script.push_back(wr(REG_HEIGHT, 13'd4096));
		script.push_back(wr(REG_MODE, DIM_W'(ROT_0)));
		script.push_back(chk(8'h80, 24'd0, 1'b0));
		script.push_back(wr(REG_WIDTH, 13'd2));
		script.push_back(wr(REG_HEIGHT, 13'd3));
		script.push_back(wr(REG_MODE, DIM_W'(ROT_90)));
		for (int i = 0; i < 6; i++) begin
			script.push_back(px(PIX_W'(8'h10 + i)));
		end
		script.push_back(wr(REG_MODE, DIM_W'(ROT_180)));
		script.push_back(px(8'h55));
		script.push_back(px(8'hAA));
		script.push_back(wr(REG_WIDTH, 13'd3));
		script.push_back(wr(REG_HEIGHT, 13'd2));
		script.push_back(wr(REG_MODE, DIM_W'(ROT_270)));
		script.push_back(px(8'h01));
		script.push_back(px(8'h02));
		script.push_back(px(8'h04));
		script.push_back(wr(REG_UNUSED, 13'd8191));
		script.push_back(px(8'h08));
		script.push_back(px(8'hF0));
		script.push_back(wr(REG_MODE, DIM_W'(ROT_0)));
		script.push_back(chk(8'h0F, 24'd0, 1'b0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			case (script[i].kind)
				STEP_WRITE: begin
					write_reg(script[i].index, script[i].data);
				end
				STEP_CHECKED: begin
					send_pixel(script[i].pixel, 1'b1, script[i].dest_index, script[i].last);
				end
				default: begin
					send_pixel(script[i].pixel, 1'b0, '0, 1'b0);
				end
			endcase
		end

		for (int segment = 0; segment < 3; segment++) begin
			case (segment)
				0: begin
					src_idle_pct = 33;
					dst_idle_pct = 47;
				end
				1: begin
					src_idle_pct = 47;
					dst_idle_pct = 33;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			segment_end = pixels_sent + PIXELS_PER_SEGMENT;
			while (pixels_sent < segment_end) begin
				run_frame_setting();
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
